// ===== design/jsv_pkg.sv =====
// Shared constants, types and helpers of the JSON syntax validator.
package jsv_pkg;

	localparam int unsigned JSV_MAX_DEPTH = 64;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_L      = 8'h6C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [3:0] ST_VALID       = 4'd0;
	localparam logic [3:0] ST_END_STRING  = 4'd1;
	localparam logic [3:0] ST_BAD_ESCAPE  = 4'd2;
	localparam logic [3:0] ST_FRACTION    = 4'd3;
	localparam logic [3:0] ST_EXP_QUOTE   = 4'd4;
	localparam logic [3:0] ST_EXP_COLON   = 4'd5;
	localparam logic [3:0] ST_EXP_RBRACE  = 4'd6;
	localparam logic [3:0] ST_EXP_RBRACK  = 4'd7;
	localparam logic [3:0] ST_END_VALUE   = 4'd8;
	localparam logic [3:0] ST_BAD_TOKEN   = 4'd9;
	localparam logic [3:0] ST_GARBAGE     = 4'd10;
	localparam logic [3:0] ST_TOO_DEEP    = 4'd11;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic [13:0] {
		MODE_VALUE     = 14'b00_0000_0000_0001,
		MODE_ARR_FIRST = 14'b00_0000_0000_0010,
		MODE_OBJ_FIRST = 14'b00_0000_0000_0100,
		MODE_KEY       = 14'b00_0000_0000_1000,
		MODE_COLON     = 14'b00_0000_0001_0000,
		MODE_AFTER     = 14'b00_0000_0010_0000,
		MODE_NUMBER    = 14'b00_0000_0100_0000,
		MODE_NULL      = 14'b00_0000_1000_0000,
		MODE_STR_VAL   = 14'b00_0001_0000_0000,
		MODE_STR_KEY   = 14'b00_0010_0000_0000,
		MODE_ESC_VAL   = 14'b00_0100_0000_0000,
		MODE_ESC_KEY   = 14'b00_1000_0000_0000,
		MODE_USKIP_VAL = 14'b01_0000_0000_0000,
		MODE_USKIP_KEY = 14'b10_0000_0000_0000
	} parse_mode_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == CNT_MAX) ? v : v + 32'd1;
	endfunction

endpackage

// ===== design/jsv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module jsv_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/json_syntax_validator_unit.sv =====
// JSON syntax validator, stack in RAM: one byte per cycle unless the terminator stalls.
// Throughput: one byte per cycle unless stalled, set by the stack-top update and RAM read.
// The result appears in the output register in the cycle after the terminator is accepted.
// The stack entry below the top is prefetched each cycle and forwarded after a push.
// Reset (arst_n low or the terminator byte) restores the counters and mode at once;
// the stack RAM needs no clearing.
module json_syntax_validator_unit #(
	parameter int unsigned MAX_DEPTH = jsv_pkg::JSV_MAX_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  status,
	output logic [31:0] error_line,
	output logic [31:0] error_column
);
	import jsv_pkg::*;

	localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
	localparam int unsigned RAM_DEPTH = (MAX_DEPTH > 1) ? MAX_DEPTH : 2;
	localparam int unsigned AW = $clog2(RAM_DEPTH);

	parse_mode_t   mode_q, mode_n;
	logic [DW-1:0] depth_q, depth_n;
	logic          top_q, top_n;
	logic [1:0]    null_prog_q, null_prog_n;
	logic [31:0]   line_q, line_n;
	logic [31:0]   col_q, col_n;
	logic [31:0]   tok_col_q, tok_col_n;
	logic [3:0]    err_q, err_n;
	logic [31:0]   err_line_q, err_line_n;
	logic [31:0]   err_col_q, err_col_n;
	logic          fwd_q;
	logic          fwd_data_q;

	logic          result_valid_q;
	logic [3:0]    status_q;
	logic [31:0]   error_line_q;
	logic [31:0]   error_column_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic          ram_rdata;
	logic          below;
	logic          accept;
	logic          term;

	assign term       = (data_byte == CH_NUL);
	assign data_stall = result_valid_q && result_stall && term;
	assign accept     = data_valid && !data_stall;
	assign below      = fwd_q ? fwd_data_q : ram_rdata;

	always_comb begin
		parse_mode_t m;
		logic        counted_nl;
		logic        fail_en;
		logic [3:0]  fail_code;
		logic [31:0] fail_col;
		logic        do_value;
		logic        do_key;
		logic        do_after;
		logic        do_close;
		logic        do_push;
		logic        push_obj;

		m           = mode_q;
		counted_nl  = 1'b0;
		fail_en     = 1'b0;
		fail_code   = ST_VALID;
		fail_col    = col_q;
		do_value    = 1'b0;
		do_key      = 1'b0;
		do_after    = 1'b0;
		do_close    = 1'b0;
		do_push     = 1'b0;
		push_obj    = 1'b0;
		mode_n      = mode_q;
		depth_n     = depth_q;
		top_n       = top_q;
		null_prog_n = null_prog_q;
		tok_col_n   = tok_col_q;
		ram_we      = 1'b0;
		ram_waddr   = AW'(depth_q - DW'(1));

		if (err_q == ST_VALID) begin
			if (m == MODE_NUMBER) begin
				if (data_byte == CH_DOT) begin
					fail_en   = 1'b1;
					fail_code = ST_FRACTION;
				end else if (!is_digit(data_byte)) begin
					m      = MODE_AFTER;
					mode_n = MODE_AFTER;
				end
			end
			if (!fail_en && m != MODE_NUMBER) begin
				counted_nl = (data_byte == CH_LF) && (m == MODE_VALUE || m == MODE_ARR_FIRST ||
					m == MODE_OBJ_FIRST || m == MODE_KEY || m == MODE_COLON || m == MODE_AFTER);
				unique case (m) inside
					MODE_VALUE: begin
						do_value = 1'b1;
					end
					MODE_ARR_FIRST: begin
						if (!is_ws(data_byte)) begin
							if (data_byte == CH_RBRACK) do_close = 1'b1;
							else do_value = 1'b1;
						end
					end
					MODE_OBJ_FIRST: begin
						if (!is_ws(data_byte)) begin
							if (data_byte == CH_RBRACE) do_close = 1'b1;
							else do_key = 1'b1;
						end
					end
					MODE_KEY: begin
						do_key = 1'b1;
					end
					MODE_COLON: begin
						if (!is_ws(data_byte)) begin
							if (data_byte == CH_COLON) begin
								mode_n = MODE_VALUE;
							end else begin
								fail_en   = 1'b1;
								fail_code = ST_EXP_COLON;
							end
						end
					end
					MODE_NULL: begin
						if (data_byte == ((null_prog_q == 2'd0) ? CH_U : CH_L)) begin
							if (null_prog_q >= 2'd2) mode_n = MODE_AFTER;
							else null_prog_n = null_prog_q + 2'd1;
						end else begin
							fail_en   = 1'b1;
							fail_code = ST_BAD_TOKEN;
							fail_col  = tok_col_q;
						end
					end
					MODE_STR_VAL, MODE_STR_KEY: begin
						if (data_byte == CH_QUOTE) begin
							mode_n = (m == MODE_STR_KEY) ? MODE_COLON : MODE_AFTER;
						end else if (data_byte == CH_NUL) begin
							fail_en   = 1'b1;
							fail_code = ST_END_STRING;
						end else if (data_byte == CH_BSLASH) begin
							mode_n = (m == MODE_STR_KEY) ? MODE_ESC_KEY : MODE_ESC_VAL;
						end
					end
					MODE_ESC_VAL, MODE_ESC_KEY: begin
						if (data_byte == CH_QUOTE || data_byte == CH_BSLASH ||
							data_byte == CH_SLASH || data_byte == CH_B || data_byte == CH_F ||
							data_byte == CH_N || data_byte == CH_R || data_byte == CH_T) begin
							mode_n = (m == MODE_ESC_KEY) ? MODE_STR_KEY : MODE_STR_VAL;
						end else if (data_byte == CH_U) begin
							mode_n = (m == MODE_ESC_KEY) ? MODE_USKIP_KEY : MODE_USKIP_VAL;
						end else begin
							fail_en   = 1'b1;
							fail_code = ST_BAD_ESCAPE;
						end
					end
					MODE_USKIP_VAL, MODE_USKIP_KEY: begin
						if (data_byte == CH_NUL) begin
							fail_en   = 1'b1;
							fail_code = ST_END_STRING;
						end else begin
							mode_n = (m == MODE_USKIP_KEY) ? MODE_STR_KEY : MODE_STR_VAL;
						end
					end
					default: begin
						do_after = 1'b1;
					end
				endcase

				if (do_value) begin
					mode_n = MODE_VALUE;
					if (!is_ws(data_byte)) begin
						if (data_byte == CH_LBRACE) begin
							do_push  = 1'b1;
							push_obj = 1'b1;
						end else if (data_byte == CH_LBRACK) begin
							do_push = 1'b1;
						end else if (data_byte == CH_QUOTE) begin
							mode_n = MODE_STR_VAL;
						end else if (data_byte == CH_MINUS || is_digit(data_byte)) begin
							mode_n = MODE_NUMBER;
						end else if (data_byte == CH_N) begin
							mode_n      = MODE_NULL;
							null_prog_n = 2'd0;
							tok_col_n   = col_q;
						end else if (data_byte == CH_NUL) begin
							fail_en   = 1'b1;
							fail_code = ST_END_VALUE;
						end else begin
							fail_en   = 1'b1;
							fail_code = ST_BAD_TOKEN;
						end
					end
				end

				if (do_key) begin
					mode_n = MODE_KEY;
					if (!is_ws(data_byte)) begin
						if (data_byte == CH_QUOTE) begin
							mode_n = MODE_STR_KEY;
						end else begin
							fail_en   = 1'b1;
							fail_code = ST_EXP_QUOTE;
						end
					end
				end

				if (do_after) begin
					mode_n = MODE_AFTER;
					if (!is_ws(data_byte)) begin
						if (depth_q == '0) begin
							if (data_byte != CH_NUL) begin
								fail_en   = 1'b1;
								fail_code = ST_GARBAGE;
							end
						end else if (top_q) begin
							if (data_byte == CH_RBRACE) begin
								do_close = 1'b1;
							end else if (data_byte == CH_COMMA) begin
								mode_n = MODE_KEY;
							end else begin
								fail_en   = 1'b1;
								fail_code = ST_EXP_RBRACE;
							end
						end else begin
							if (data_byte == CH_RBRACK) begin
								do_close = 1'b1;
							end else if (data_byte == CH_COMMA) begin
								mode_n = MODE_VALUE;
							end else begin
								fail_en   = 1'b1;
								fail_code = ST_EXP_RBRACK;
							end
						end
					end
				end

				if (do_push) begin
					if (depth_q >= DW'(MAX_DEPTH)) begin
						fail_en   = 1'b1;
						fail_code = ST_TOO_DEEP;
					end else begin
						ram_we  = accept && (depth_q != '0);
						top_n   = push_obj;
						depth_n = depth_q + DW'(1);
						mode_n  = push_obj ? MODE_OBJ_FIRST : MODE_ARR_FIRST;
					end
				end

				if (do_close) begin
					if (depth_q != '0) depth_n = depth_q - DW'(1);
					top_n  = below;
					mode_n = MODE_AFTER;
				end
			end
		end

		err_n      = err_q;
		err_line_n = err_line_q;
		err_col_n  = err_col_q;
		if (fail_en) begin
			err_n      = fail_code;
			err_line_n = line_q;
			err_col_n  = fail_col;
		end

		if (counted_nl) begin
			col_n  = '0;
			line_n = sat_inc(line_q);
		end else begin
			col_n  = sat_inc(col_q);
			line_n = line_q;
		end

		ram_raddr = AW'(depth_n - DW'(2));
		if (!accept) begin
			ram_raddr = AW'(depth_q - DW'(2));
		end
	end

	jsv_ram #(
		.WIDTH(1),
		.DEPTH(RAM_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(top_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_VALUE;
			depth_q     <= '0;
			top_q       <= 1'b0;
			null_prog_q <= '0;
			line_q      <= 32'd1;
			col_q       <= '0;
			tok_col_q   <= '0;
			err_q       <= ST_VALID;
			err_line_q  <= '0;
			err_col_q   <= '0;
			fwd_q       <= 1'b0;
			fwd_data_q  <= 1'b0;
		end else begin
			fwd_q      <= ram_we;
			fwd_data_q <= top_q;
			if (accept) begin
				if (term) begin
					mode_q      <= MODE_VALUE;
					depth_q     <= '0;
					top_q       <= 1'b0;
					null_prog_q <= '0;
					line_q      <= 32'd1;
					col_q       <= '0;
					tok_col_q   <= '0;
					err_q       <= ST_VALID;
					err_line_q  <= '0;
					err_col_q   <= '0;
				end else begin
					mode_q      <= mode_n;
					depth_q     <= depth_n;
					top_q       <= top_n;
					null_prog_q <= null_prog_n;
					line_q      <= line_n;
					col_q       <= col_n;
					tok_col_q   <= tok_col_n;
					err_q       <= err_n;
					err_line_q  <= err_line_n;
					err_col_q   <= err_col_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept && term) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && term) begin
			status_q       <= err_n;
			error_line_q   <= err_line_n;
			error_column_q <= err_col_n;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign error_line   = error_line_q;
	assign error_column = error_column_q;

endmodule
